### rtl/core/nalsplit_pkg.sv
// ----------------------------------------------------------------------------
// nalsplit_pkg: shared types and helpers for the Annex B unit splitter
// Offset width, header field constants and the unit report record.
// ----------------------------------------------------------------------------
package nalsplit_pkg;

  // Width of the internal byte counter and of stored unit offsets.
  localparam int OFFSET_BITS = 32;

  localparam logic [7:0] START_BYTE = 8'h01;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;
  localparam logic [4:0] TYPE_MASK  = 5'h1F;
  localparam logic [4:0] IDR_TYPE   = 5'd5;

  // Saturated zero run of three or more bytes.
  localparam logic [1:0] RUN_MAX = 2'd3;

  typedef logic [OFFSET_BITS-1:0] offset_t;

  // One unit report, as it leaves the block.
  typedef struct packed {
    logic [31:0] unit_offset;
    logic [31:0] unit_size;
    logic [4:0]  unit_type;
    logic        is_picture;
    logic        is_idr;
    logic [31:0] picture_number;
    logic        stream_end;
  } unit_t;

  // Clip an offset-width value to the 32-bit output range.
  function automatic logic [31:0] clip32(input offset_t v);
    logic [OFFSET_BITS+31:0] wide;
    wide = {32'd0, v};
    if ((wide >> 32) != '0) begin
      clip32 = '1;
    end else begin
      clip32 = wide[31:0];
    end
  endfunction

endpackage

### rtl/core/nalsplit_byte_if.sv
// ----------------------------------------------------------------------------
// nalsplit_byte_if: byte stream channel
// Valid/ready channel carrying one stream byte and its end-of-stream mark.
// ----------------------------------------------------------------------------
interface nalsplit_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/core/nalsplit_unit_if.sv
// ----------------------------------------------------------------------------
// nalsplit_unit_if: unit report channel
// Valid/ready channel carrying one report per completed unit.
// ----------------------------------------------------------------------------
interface nalsplit_unit_if;
  logic        valid;
  logic        ready;
  logic [31:0] unit_offset;
  logic [31:0] unit_size;
  logic [4:0]  unit_type;
  logic        is_picture;
  logic        is_idr;
  logic [31:0] picture_number;
  logic        stream_end;

  modport source (
    output valid, output unit_offset, output unit_size, output unit_type,
    output is_picture, output is_idr, output picture_number,
    output stream_end, input ready
  );
  modport sink (
    input valid, input unit_offset, input unit_size, input unit_type,
    input is_picture, input is_idr, input picture_number,
    input stream_end, output ready
  );
endinterface

### rtl/core/nalsplit_report.sv
// ----------------------------------------------------------------------------
// nalsplit_report: unit report formatter
// Builds the report record of a closing unit from its bounds and type.
// ----------------------------------------------------------------------------
module nalsplit_report (
  input  nalsplit_pkg::offset_t unit_start,
  input  nalsplit_pkg::offset_t unit_end,
  input  logic [4:0]            header_type,
  input  logic [31:0]           picture_count,
  input  logic                  at_end,
  output nalsplit_pkg::unit_t   report,
  output logic                  picture
);

  nalsplit_pkg::offset_t size;

  always_comb begin
    size = (unit_end >= unit_start) ? unit_end - unit_start : '0;
    picture = header_type inside {[5'd1:5'd5]};

    report.unit_offset    = nalsplit_pkg::clip32(unit_start);
    report.unit_size      = nalsplit_pkg::clip32(size);
    report.unit_type      = header_type;
    report.is_picture     = picture;
    report.is_idr         = (header_type == nalsplit_pkg::IDR_TYPE);
    report.picture_number = picture ? picture_count : 32'd0;
    report.stream_end     = at_end;
  end

endmodule

### rtl/core/h264_annexb_nal_splitter_core.sv
// ----------------------------------------------------------------------------
// h264_annexb_nal_splitter_core: Annex B start code parser
// Scans an H.264 Annex B byte stream and reports the bounds and type of
// every unit it contains.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Word                    Notes
//   stream   in         data_byte, last_byte    one stream byte per word
//   units    out        unit report (7 fields)  at most one per input word
//
// One byte is taken per clock while ready. The scan state (byte counter, zero
// run, open unit) updates at the edge that takes a byte, and any report that
// byte causes lands in the output register at the same edge, so a report
// shows the cycle after its byte. The output register is a single stage: a new
// byte is taken when that register is empty or is being drained in the same
// cycle, so a stalled consumer stalls the input only while a report waits.
// rst is synchronous and clears the scan state and the output valid flag.
// ----------------------------------------------------------------------------
module h264_annexb_nal_splitter_core (
  input logic             clk,
  input logic             rst,
  nalsplit_byte_if.sink   stream,
  nalsplit_unit_if.source units
);

  localparam nalsplit_pkg::offset_t OFFSET_MAX = '1;

  // Scan state.
  nalsplit_pkg::offset_t byte_count;
  logic [1:0]            zero_run;
  logic                  unit_open;
  logic                  header_pending;
  nalsplit_pkg::offset_t open_unit_start;
  logic [4:0]            open_unit_type;
  logic [31:0]           picture_count;

  // Output register.
  logic                  out_valid;
  nalsplit_pkg::unit_t   out_unit;

  logic                  take;
  logic                  start_code;
  logic                  close_by_code;
  logic                  close_by_end;
  logic                  emit;
  logic [4:0]            byte_type;
  logic [4:0]            closing_type;
  nalsplit_pkg::offset_t code_start;
  nalsplit_pkg::offset_t end_pos;
  nalsplit_pkg::offset_t closing_end;
  nalsplit_pkg::unit_t   report;
  logic                  report_picture;

  // A byte may enter when the result register is free or drains this cycle.
  assign stream.ready = !out_valid || units.ready;
  assign take         = stream.valid && stream.ready;

  always_comb begin
    byte_type  = stream.data_byte[4:0] & nalsplit_pkg::TYPE_MASK;
    start_code = (stream.data_byte == nalsplit_pkg::START_BYTE) && (zero_run >= 2'd2);

    // Three or more zeros: the unit starts three bytes before the 01;
    // extra leading zeros stay with the previous unit.
    if (zero_run == nalsplit_pkg::RUN_MAX) begin
      code_start = (byte_count >= nalsplit_pkg::offset_t'(3))
                   ? byte_count - nalsplit_pkg::offset_t'(3) : '0;
    end else begin
      code_start = (byte_count >= nalsplit_pkg::offset_t'(2))
                   ? byte_count - nalsplit_pkg::offset_t'(2) : '0;
    end

    // A start code closes a unit only once that unit has its header byte.
    close_by_code = start_code && unit_open && !header_pending;
    // The last byte closes the open unit; if it is the header byte itself,
    // the unit ends right here and takes its type from this byte. A start
    // code that ends the stream opens a unit with no header, which is dropped.
    close_by_end  = stream.last_byte && !start_code && unit_open;
    emit          = close_by_code || close_by_end;

    end_pos      = (byte_count == OFFSET_MAX) ? OFFSET_MAX
                   : byte_count + nalsplit_pkg::offset_t'(1);
    closing_end  = close_by_code ? code_start : end_pos;
    closing_type = (header_pending && !close_by_code) ? byte_type : open_unit_type;
  end

  nalsplit_report u_report (
    .unit_start    (open_unit_start),
    .unit_end      (closing_end),
    .header_type   (closing_type),
    .picture_count (picture_count),
    .at_end        (stream.last_byte),
    .report        (report),
    .picture       (report_picture)
  );

  // Scan state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      zero_run        <= '0;
      unit_open       <= 1'b0;
      header_pending  <= 1'b0;
      open_unit_start <= '0;
      open_unit_type  <= '0;
      picture_count   <= '0;
    end else if (take) begin
      if (stream.last_byte) begin
        // The next byte begins a fresh stream at offset zero.
        byte_count      <= '0;
        zero_run        <= '0;
        unit_open       <= 1'b0;
        header_pending  <= 1'b0;
        open_unit_start <= '0;
        open_unit_type  <= '0;
        picture_count   <= '0;
      end else begin
        if (byte_count != OFFSET_MAX) begin
          byte_count <= byte_count + nalsplit_pkg::offset_t'(1);
        end
        if (emit && report_picture && (picture_count != 32'hFFFF_FFFF)) begin
          picture_count <= picture_count + 32'd1;
        end
        if (start_code) begin
          unit_open       <= 1'b1;
          header_pending  <= 1'b1;
          open_unit_start <= code_start;
          open_unit_type  <= '0;
          zero_run        <= '0;
        end else begin
          // The header byte is ordinary data too: a zero header counts
          // toward the next zero run.
          if (header_pending) begin
            open_unit_type <= byte_type;
            header_pending <= 1'b0;
          end
          if (stream.data_byte == nalsplit_pkg::ZERO_BYTE) begin
            if (zero_run != nalsplit_pkg::RUN_MAX) begin
              zero_run <= zero_run + 2'd1;
            end
          end else begin
            zero_run <= '0;
          end
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= emit;
    end else if (units.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_unit <= report;
    end
  end

  assign units.valid          = out_valid;
  assign units.unit_offset    = out_unit.unit_offset;
  assign units.unit_size      = out_unit.unit_size;
  assign units.unit_type      = out_unit.unit_type;
  assign units.is_picture     = out_unit.is_picture;
  assign units.is_idr         = out_unit.is_idr;
  assign units.picture_number = out_unit.picture_number;
  assign units.stream_end     = out_unit.stream_end;

endmodule
